@@ rtl/gxb_pkg.sv @@
package gxb_pkg;

    localparam int unsigned NSTG = 13;      // pipeline depth, one result per accepted request
    localparam int unsigned DIV_FIRST = 6;  // first divider stage
    localparam int unsigned DIV_LAST = 9;   // last divider stage
    localparam int unsigned DIV_BITS = 4;   // quotient bits resolved per divider stage

    localparam logic [15:0] FULL = 16'hFFFF;
    localparam logic [16:0] HALF = 17'd32768;
    localparam logic [33:0] NUM_SAT = 34'h0_FFFF_0000;  // 65536 * 65535

    typedef enum logic {
        CFG_OPACITY  = 1'b0,
        CFG_USE_MASK = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [2:0][15:0] base;
        logic [2:0][15:0] layer;
        logic [15:0]      ba;
        logic [15:0]      la;
        logic [15:0]      mask;
        logic [31:0]      prod;
        logic [15:0]      ca;
        logic [15:0]      na;
        logic [15:0]      rem;
        logic [15:0]      low;
        logic [15:0]      q;
        logic             byp;
        logic [2:0][33:0] cprod;
        logic [2:0][34:0] num;
        logic [2:0][15:0] res;
    } t_stage;

    // floor(x / 65535) for x below 65536 * 65535:
    // x = 65535*h + (h + l), and h + l never reaches three times 65535
    function automatic logic [15:0] div_full(input logic [31:0] x);
        logic [16:0] s;
        logic [16:0] q;
        s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
        q = {1'b0, x[31:16]} + 17'(s >= 17'd65535) + 17'(s >= 17'd131070);
        return q[15:0];
    endfunction

endpackage

@@ rtl/grain_extract_blend.sv @@
// Grain-extract compositing of an RGBA layer pixel over an RGBA base pixel.
// Input: a pixel request is taken at each rising edge with start high and busy
// low. busy is always low, so a new pixel may be offered in every cycle.
// Output: o_valid marks a result for exactly one cycle; the receiver cannot
// stall, so the pipeline never holds. Results leave in request order.
// Throughput: one pixel per cycle. The depth is set by the chain of two alpha
// multiplies with divide-by-full-scale, the new-alpha multiply, a four-stage
// restoring divider for the mixing ratio (four quotient bits per stage) and
// the channel multiply, sum and clamp.
// Configuration: APB port, opacity at byte address 0, use_mask at 4; the byte
// offset inside a word is ignored. Write only while no pixel is in flight.
// Reset (synchronous, active low) drops all pixels in flight and sets
// opacity to full scale and use_mask to 0.
module grain_extract_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_base_red,
    input  logic [15:0] i_base_green,
    input  logic [15:0] i_base_blue,
    input  logic [15:0] i_base_alpha,
    input  logic [15:0] i_layer_red,
    input  logic [15:0] i_layer_green,
    input  logic [15:0] i_layer_blue,
    input  logic [15:0] i_layer_alpha,
    input  logic [15:0] i_mask_value,
    input  logic        i_last_in,
    output logic        o_valid,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [15:0] o_out_alpha,
    output logic        o_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]     r_opacity;
    logic            r_use_mask;
    gxb_pkg::t_stage r_st [gxb_pkg::NSTG];
    gxb_pkg::t_stage n_st [gxb_pkg::NSTG];
    logic            cfg_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity  <= gxb_pkg::FULL;
            r_use_mask <= 1'b0;
        end else if (cfg_wr) begin
            unique case (gxb_pkg::t_cfg_reg'(paddr[2]))
                gxb_pkg::CFG_OPACITY:  r_opacity  <= pwdata[15:0];
                gxb_pkg::CFG_USE_MASK: r_use_mask <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (gxb_pkg::t_cfg_reg'(paddr[2]))
            gxb_pkg::CFG_OPACITY:  prdata = {16'b0, r_opacity};
            gxb_pkg::CFG_USE_MASK: prdata = {31'b0, r_use_mask};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        logic [15:0]        m;
        logic [15:0]        na;
        logic [31:0]        dvd;
        logic [16:0]        t;
        logic signed [16:0] sd;
        logic signed [16:0] rq;
        logic signed [33:0] pr;
        logic signed [34:0] bs;
        logic signed [34:0] nm;

        // stage 0: capture request, min alpha times opacity
        n_st[0]          = r_st[0];
        n_st[0].vld      = start && !busy;
        n_st[0].last     = i_last_in;
        n_st[0].base     = {i_base_blue, i_base_green, i_base_red};
        n_st[0].layer    = {i_layer_blue, i_layer_green, i_layer_red};
        n_st[0].ba       = i_base_alpha;
        n_st[0].la       = i_layer_alpha;
        n_st[0].mask     = i_mask_value;
        m                = (i_base_alpha < i_layer_alpha) ? i_base_alpha : i_layer_alpha;
        n_st[0].prod     = 32'(m) * 32'(r_opacity);

        for (int s = 1; s < gxb_pkg::NSTG; s++) begin
            n_st[s] = r_st[s-1];
        end

        n_st[1].ca   = gxb_pkg::div_full(r_st[0].prod);
        n_st[2].prod = 32'(r_st[1].ca) * 32'(r_st[1].mask);
        if (r_use_mask) begin
            n_st[3].ca = gxb_pkg::div_full(r_st[2].prod);
        end
        n_st[4].prod = 32'(gxb_pkg::FULL - r_st[3].ba) * 32'(r_st[3].ca);

        // stage 5: new alpha, seed the ratio divider with ca * 65535
        na           = r_st[4].ba + gxb_pkg::div_full(r_st[4].prod);
        dvd          = {r_st[4].ca, 16'b0} - 32'(r_st[4].ca);
        n_st[5].na   = na;
        n_st[5].byp  = (r_st[4].ca == 16'd0) || (na == 16'd0);
        n_st[5].rem  = dvd[31:16];
        n_st[5].low  = dvd[15:0];
        n_st[5].q    = '0;

        // restoring division; the remainder stays below na
        for (int s = gxb_pkg::DIV_FIRST; s <= gxb_pkg::DIV_LAST; s++) begin
            for (int k = 0; k < gxb_pkg::DIV_BITS; k++) begin
                t           = {n_st[s].rem, n_st[s].low[15]};
                n_st[s].low = {n_st[s].low[14:0], 1'b0};
                if (t >= {1'b0, n_st[s].na}) begin
                    t         = t - {1'b0, n_st[s].na};
                    n_st[s].q = {n_st[s].q[14:0], 1'b1};
                end else begin
                    n_st[s].q = {n_st[s].q[14:0], 1'b0};
                end
                n_st[s].rem = t[15:0];
            end
        end

        for (int c = 0; c < 3; c++) begin
            sd = $signed(gxb_pkg::HALF - {1'b0, r_st[9].layer[c]});
            rq = $signed({1'b0, r_st[9].q});
            pr = sd * rq;
            n_st[10].cprod[c] = pr;
        end

        for (int c = 0; c < 3; c++) begin
            bs = $signed({3'b0, r_st[10].base[c], 16'b0}) - $signed(35'(r_st[10].base[c]));
            nm = bs + $signed(r_st[10].cprod[c]);
            n_st[11].num[c] = nm;
        end

        // stage 12: clamp and scale back; zero alpha passes the base colour
        for (int c = 0; c < 3; c++) begin
            priority if (r_st[11].byp) begin
                n_st[12].res[c] = r_st[11].base[c];
            end else if (r_st[11].num[c][34]) begin
                n_st[12].res[c] = 16'd0;
            end else if (r_st[11].num[c][33:0] >= gxb_pkg::NUM_SAT) begin
                n_st[12].res[c] = gxb_pkg::FULL;
            end else begin
                n_st[12].res[c] = gxb_pkg::div_full(r_st[11].num[c][31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < gxb_pkg::NSTG; s++) begin
                r_st[s].vld <= 1'b0;
            end
        end else begin
            r_st <= n_st;
        end
    end

    assign o_valid     = r_st[gxb_pkg::NSTG-1].vld;
    assign o_out_red   = r_st[gxb_pkg::NSTG-1].res[0];
    assign o_out_green = r_st[gxb_pkg::NSTG-1].res[1];
    assign o_out_blue  = r_st[gxb_pkg::NSTG-1].res[2];
    assign o_out_alpha = r_st[gxb_pkg::NSTG-1].ba;
    assign o_last_out  = r_st[gxb_pkg::NSTG-1].last;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(gxb_pkg::NSTG) o_valid)
        else $error("request did not produce a result on time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, gxb_pkg::NSTG))
        else $error("result without a matching request");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_alpha == $past(i_base_alpha, gxb_pkg::NSTG))
                    && (o_last_out == $past(i_last_in, gxb_pkg::NSTG)))
        else $error("alpha or last flag out of step with its pixel");

    a_opacity_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && !paddr[2]) |=> (r_opacity == $past(pwdata[15:0])))
        else $error("opacity write lost");

endmodule
